// File: rtl/core/bcbi_pkg.sv
package bcbi_pkg;

  // Default sizes of the block
  localparam int MAX_CODE_LEN_DEF = 16;
  localparam int NUM_BEACONS_DEF  = 64;
  localparam int SAMPLE_WIDTH_DEF = 16;

  // Fixed field widths
  localparam int OP_W      = 2;
  localparam int IDX_IN_W  = 6;
  localparam int PAT_W     = 16;
  localparam int BRIGHT_W  = 16;
  localparam int ID_W      = 7;
  localparam int STATUS_W  = 3;
  localparam int LEN_CFG_W = 5;
  localparam int DIFF_W    = 16;

  // Register port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // Register reset values (contrast default is 0.3 in six-fraction-bit fixed point)
  localparam logic [LEN_CFG_W-1:0] PATTERN_LENGTH_RST = 5'd16;
  localparam logic [DIFF_W-1:0]    MIN_DIFF_RST       = 16'd19;
  localparam logic                 KEEP_ID_RST        = 1'b1;

  // Id reported when nothing is identified
  localparam logic [ID_W-1:0] ID_NONE = '1;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_MATCH   = 3'd0,
    STS_KEPT    = 3'd1,
    STS_SHORT   = 3'd2,
    STS_LOW     = 3'd3,
    STS_NOMATCH = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    REG_PATTERN_LENGTH = 2'd0,
    REG_MIN_DIFF       = 2'd1,
    REG_KEEP_ID        = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_MINMAX,
    CS_CONTRAST,
    CS_ROTATE,
    CS_SCAN,
    CS_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic [LEN_CFG_W-1:0] pattern_length;
    logic [DIFF_W-1:0]    min_diff;
    logic                 keep_id;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic    accept;
    logic    mm_step;
    logic    eval;
    logic    rot;
    logic    scan;
    logic    set_result;
    status_t res_status;
    logic    load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic count_short;
    logic mm_last;
    logic low_contrast;
    logic keep;
    logic hit;
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/core/bcbi_regs.sv
module bcbi_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bcbi_pkg::ADDR_W-1:0]  paddr,
  input  logic [bcbi_pkg::DATA_W-1:0]  pwdata,
  output logic [bcbi_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output bcbi_pkg::cfg_t               cfg
);
  import bcbi_pkg::*;

  logic     wr_en;
  reg_idx_t reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = reg_idx_t'(paddr[3:2]);

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_length <= PATTERN_LENGTH_RST;
      cfg.min_diff       <= MIN_DIFF_RST;
      cfg.keep_id        <= KEEP_ID_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_PATTERN_LENGTH: cfg.pattern_length <= pwdata[LEN_CFG_W-1:0];
        REG_MIN_DIFF:       cfg.min_diff       <= pwdata[DIFF_W-1:0];
        REG_KEEP_ID:        cfg.keep_id        <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_sel)
      REG_PATTERN_LENGTH: prdata = DATA_W'(cfg.pattern_length);
      REG_MIN_DIFF:       prdata = DATA_W'(cfg.min_diff);
      REG_KEEP_ID:        prdata = DATA_W'(cfg.keep_id);
      default:            prdata = '0;
    endcase
  end

endmodule

// File: rtl/core/bcbi_ctrl.sv
module bcbi_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [bcbi_pkg::OP_W-1:0]   operation,
  output logic                        in_ready,
  input  bcbi_pkg::sts_t              sts,
  output bcbi_pkg::cmd_t              cmd
);
  import bcbi_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      CS_IDLE: begin
        if (in_valid && operation == OP_SAMPLE) state_next = CS_MINMAX;
      end
      CS_MINMAX: begin
        if (sts.count_short)  state_next = CS_FINISH;
        else if (sts.mm_last) state_next = CS_CONTRAST;
      end
      CS_CONTRAST: begin
        if (sts.low_contrast || sts.keep) state_next = CS_FINISH;
        else                              state_next = CS_ROTATE;
      end
      CS_ROTATE: begin
        state_next = CS_SCAN;
      end
      CS_SCAN: begin
        if (sts.hit || sts.scan_last) state_next = CS_FINISH;
      end
      CS_FINISH: begin
        if (sts.out_free) state_next = CS_IDLE;
      end
      default: state_next = CS_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.res_status = STS_SHORT;
    unique case (state)
      CS_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      CS_MINMAX: begin
        cmd.mm_step = !sts.count_short;
        if (sts.count_short) begin
          cmd.set_result = 1'b1;
          cmd.res_status = STS_SHORT;
        end
      end
      CS_CONTRAST: begin
        cmd.eval = 1'b1;
        if (sts.low_contrast) begin
          cmd.set_result = 1'b1;
          cmd.res_status = STS_LOW;
        end else if (sts.keep) begin
          cmd.set_result = 1'b1;
          cmd.res_status = STS_KEPT;
        end
      end
      CS_ROTATE: begin
        cmd.rot = 1'b1;
      end
      CS_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit) begin
          cmd.set_result = 1'b1;
          cmd.res_status = STS_MATCH;
        end else if (sts.scan_last) begin
          cmd.set_result = 1'b1;
          cmd.res_status = STS_NOMATCH;
        end
      end
      CS_FINISH: begin
        cmd.load_out = sts.out_free;
      end
      default: begin
      end
    endcase
  end

  // A finished verdict always passes through the output hand-off state
  a_result_to_finish: assert property (@(posedge clk) disable iff (rst)
    cmd.set_result |=> state == CS_FINISH)
    else $error("result set without entering finish");

  a_finish_holds: assert property (@(posedge clk) disable iff (rst)
    (state == CS_FINISH && !sts.out_free) |=> state == CS_FINISH)
    else $error("left finish while output slot busy");

  a_load_to_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> state == CS_IDLE)
    else $error("no return to idle after output load");

endmodule

// File: rtl/core/bcbi_dp.sv
module bcbi_dp #(
  parameter int MAX_CODE_LEN = bcbi_pkg::MAX_CODE_LEN_DEF,
  parameter int NUM_BEACONS  = bcbi_pkg::NUM_BEACONS_DEF,
  parameter int SAMPLE_WIDTH = bcbi_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  bcbi_pkg::cfg_t                   cfg,
  input  bcbi_pkg::cmd_t                   cmd,
  output bcbi_pkg::sts_t                   sts,
  input  logic [bcbi_pkg::OP_W-1:0]        operation,
  input  logic [bcbi_pkg::IDX_IN_W-1:0]    pattern_index,
  input  logic [bcbi_pkg::PAT_W-1:0]       pattern_bits,
  input  logic                             pattern_enabled,
  input  logic [bcbi_pkg::BRIGHT_W-1:0]    brightness,
  input  logic [bcbi_pkg::ID_W-1:0]        current_id,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [bcbi_pkg::STATUS_W-1:0]    status,
  output logic [bcbi_pkg::ID_W-1:0]        beacon_id,
  output logic                             last_bright
);
  import bcbi_pkg::*;

  localparam int LEN_W = $clog2(MAX_CODE_LEN);
  localparam int CNT_W = $clog2(MAX_CODE_LEN + 1);
  localparam int IDX_W = (NUM_BEACONS > 1) ? $clog2(NUM_BEACONS) : 1;
  localparam int SW    = SAMPLE_WIDTH;
  localparam int CMP_W = 33;

  // Sample window, index 0 newest
  logic [SW-1:0]    win [MAX_CODE_LEN];
  logic [CNT_W-1:0] sample_count;
  logic [CNT_W-1:0] n_eff;

  // Pattern table and its enable bits
  logic [PAT_W-1:0]       pat_mem [NUM_BEACONS];
  logic [NUM_BEACONS-1:0] pat_valid;
  logic                   load_ok;
  logic [IDX_W-1:0]       waddr;

  // Min/max sweep
  logic [SW-1:0]    lo, hi, diff;
  logic [LEN_W-1:0] mm_idx;
  logic [ID_W-1:0]  cur;

  // Thresholded bits and rotations
  logic [SW:0]               sum;
  logic [MAX_CODE_LEN-1:0]   thr_all;
  logic [MAX_CODE_LEN-1:0]   bits, bits_next;
  logic                      bright;
  logic [MAX_CODE_LEN-1:0]   len_mask;
  logic [2*MAX_CODE_LEN-1:0] bits_dbl;
  logic [MAX_CODE_LEN-1:0]   rot [MAX_CODE_LEN];
  logic [MAX_CODE_LEN-1:0]   rot_next [MAX_CODE_LEN];
  logic [MAX_CODE_LEN-1:0]   rot_ok;

  // Table walk
  logic [IDX_W-1:0]        k;
  logic [PAT_W-1:0]        rd_code;
  logic                    rd_valid;
  logic [IDX_W-1:0]        rd_idx;
  logic                    rd_live;
  logic [MAX_CODE_LEN-1:0] code_m;
  logic [MAX_CODE_LEN-1:0] rot_hit;

  // Result and output registers
  status_t         res_status, out_status;
  logic [ID_W-1:0] res_id, out_id;
  logic            res_bright, out_bright;

  logic acc_load, acc_sample, acc_clear;

  assign acc_load   = cmd.accept && operation == OP_LOAD;
  assign acc_sample = cmd.accept && operation == OP_SAMPLE;
  assign acc_clear  = cmd.accept && operation == OP_CLEAR;

  // Effective code length, clamped to 1..MAX_CODE_LEN
  always_comb begin
    if (cfg.pattern_length == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(cfg.pattern_length) > MAX_CODE_LEN) begin
      n_eff = CNT_W'(MAX_CODE_LEN);
    end else begin
      n_eff = CNT_W'(cfg.pattern_length);
    end
  end

  assign load_ok = 32'(pattern_index) < NUM_BEACONS;
  assign waddr   = IDX_W'(pattern_index);

  // Window shift and payload captures
  always_ff @(posedge clk) begin
    if (acc_sample) begin
      for (int i = MAX_CODE_LEN - 1; i > 0; i--) begin
        win[i] <= win[i-1];
      end
      win[0] <= SW'(brightness);
      cur    <= current_id;
      lo     <= '1;
      hi     <= '0;
      mm_idx <= '0;
    end else if (cmd.mm_step) begin
      if (win[mm_idx] < lo) lo <= win[mm_idx];
      if (win[mm_idx] > hi) hi <= win[mm_idx];
      mm_idx <= mm_idx + LEN_W'(1);
    end
    if (cmd.eval) begin
      bits   <= bits_next;
      bright <= thr_all[0];
    end
    if (cmd.rot) begin
      rot <= rot_next;
    end
  end

  // Sample count and enable bits
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      pat_valid    <= '0;
    end else begin
      if (acc_clear) begin
        sample_count <= '0;
      end else if (acc_sample && 32'(sample_count) < MAX_CODE_LEN) begin
        sample_count <= sample_count + CNT_W'(1);
      end
      if (acc_load && load_ok) begin
        pat_valid[waddr] <= pattern_enabled;
      end
    end
  end

  // Pattern memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (acc_load && load_ok) begin
      pat_mem[waddr] <= pattern_bits;
    end
    if (cmd.scan) begin
      rd_code <= pat_mem[k];
    end
  end

  // Walk control
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_live <= 1'b0;
    end else if (cmd.rot) begin
      rd_live <= 1'b0;
    end else if (cmd.scan) begin
      rd_live <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rot) begin
      k <= '0;
    end else if (cmd.scan) begin
      rd_valid <= pat_valid[k];
      rd_idx   <= k;
      if (32'(k) != NUM_BEACONS - 1) k <= k + IDX_W'(1);
    end
  end

  // Contrast and midpoint threshold
  assign diff = hi - lo;
  assign sum  = {1'b0, lo} + {1'b0, hi};

  always_comb begin
    for (int i = 0; i < MAX_CODE_LEN; i++) begin
      thr_all[i] = {win[i], 1'b0} >= sum;
    end
  end

  // Oldest-first bit string
  always_comb begin
    for (int j = 0; j < MAX_CODE_LEN; j++) begin
      if (CNT_W'(j) < n_eff) begin
        bits_next[j] = thr_all[LEN_W'(n_eff - CNT_W'(1) - CNT_W'(j))];
      end else begin
        bits_next[j] = 1'b0;
      end
    end
  end

  // Every rotation of the bit string, over the effective length
  assign len_mask = ~({MAX_CODE_LEN{1'b1}} << n_eff);
  assign bits_dbl = {{MAX_CODE_LEN{1'b0}}, bits} | ({{MAX_CODE_LEN{1'b0}}, bits} << n_eff);

  always_comb begin
    for (int r = 0; r < MAX_CODE_LEN; r++) begin
      rot_next[r] = MAX_CODE_LEN'(bits_dbl >> (n_eff - CNT_W'(r))) & len_mask;
      rot_ok[r]   = CNT_W'(r) < n_eff;
    end
  end

  // Compare the fetched code against all rotations
  assign code_m = MAX_CODE_LEN'(rd_code) & len_mask;

  always_comb begin
    for (int r = 0; r < MAX_CODE_LEN; r++) begin
      rot_hit[r] = rot_ok[r] && (code_m == rot[r]);
    end
  end

  // Status to the controller
  assign sts.count_short  = sample_count < n_eff;
  assign sts.mm_last      = (CNT_W'(mm_idx) + CNT_W'(1)) == n_eff;
  assign sts.low_contrast = CMP_W'(diff) <= CMP_W'(cfg.min_diff);
  assign sts.keep         = cfg.keep_id && !cur[ID_W-1];
  assign sts.hit          = rd_live && rd_valid && (|rot_hit);
  assign sts.scan_last    = rd_live && (32'(rd_idx) == NUM_BEACONS - 1);
  assign sts.out_free     = !out_valid || out_ready;

  // Verdict capture; a kept id is decided in the contrast cycle, before bright is registered
  always_ff @(posedge clk) begin
    if (cmd.set_result) begin
      res_status <= cmd.res_status;
      unique case (cmd.res_status)
        STS_KEPT: begin
          res_id     <= cur;
          res_bright <= thr_all[0];
        end
        STS_MATCH: begin
          res_id     <= ID_W'(rd_idx);
          res_bright <= bright;
        end
        STS_NOMATCH: begin
          res_id     <= ID_NONE;
          res_bright <= bright;
        end
        default: begin
          res_id     <= ID_NONE;
          res_bright <= 1'b0;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status <= res_status;
      out_id     <= res_id;
      out_bright <= res_bright;
    end
  end

  assign status      = out_status;
  assign beacon_id   = out_id;
  assign last_bright = out_bright;

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> sts.out_free)
    else $error("output overwritten before transfer");

  a_scan_enough: assert property (@(posedge clk) disable iff (rst)
    cmd.scan |-> !sts.count_short)
    else $error("table walk with a short window");

  a_mm_range: assert property (@(posedge clk) disable iff (rst)
    cmd.mm_step |-> CNT_W'(mm_idx) < n_eff)
    else $error("min/max sweep past window length");

  a_no_verdict_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_status == STS_SHORT || out_status == STS_LOW))
      |-> (!out_bright && out_id == ID_NONE))
    else $error("fields set on an unclassified result");

endmodule

// File: rtl/core/blink_code_beacon_identifier_unit.sv
// To out_valid: too few samples go to finish; kept or low contrast follow the min/max
// sweep over pattern_length samples and the contrast check; else the rotations are built
// and the pattern memory is walked one entry per cycle to a hit or the last entry. One
// sample at a time: the next transfer is taken in the cycle after the result is loaded
// (load, clear: no result); a result waiting in the output register holds off the next
// one. Reset restores register defaults, empties the window and clears all enables.
module blink_code_beacon_identifier_unit #(
  parameter int MAX_CODE_LEN = bcbi_pkg::MAX_CODE_LEN_DEF,
  parameter int NUM_BEACONS  = bcbi_pkg::NUM_BEACONS_DEF,
  parameter int SAMPLE_WIDTH = bcbi_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [bcbi_pkg::ADDR_W-1:0]          paddr,
  input  logic [bcbi_pkg::DATA_W-1:0]          pwdata,
  output logic [bcbi_pkg::DATA_W-1:0]          prdata,
  output logic                                 pready,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [bcbi_pkg::OP_W-1:0]            operation,
  input  logic [bcbi_pkg::IDX_IN_W-1:0]        pattern_index,
  input  logic [bcbi_pkg::PAT_W-1:0]           pattern_bits,
  input  logic                                 pattern_enabled,
  input  logic [bcbi_pkg::BRIGHT_W-1:0]        brightness,
  input  logic signed [bcbi_pkg::ID_W-1:0]     current_id,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [bcbi_pkg::STATUS_W-1:0]        status,
  output logic signed [bcbi_pkg::ID_W-1:0]     beacon_id,
  output logic                                 last_bright
);
  import bcbi_pkg::*;

  cfg_t            cfg;
  cmd_t            cmd;
  sts_t            sts;
  logic [ID_W-1:0] id_out;

  bcbi_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bcbi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (operation),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bcbi_dp #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .NUM_BEACONS  (NUM_BEACONS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .cmd             (cmd),
    .sts             (sts),
    .operation       (operation),
    .pattern_index   (pattern_index),
    .pattern_bits    (pattern_bits),
    .pattern_enabled (pattern_enabled),
    .brightness      (brightness),
    .current_id      (current_id),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .status          (status),
    .beacon_id       (id_out),
    .last_bright     (last_bright)
  );

  assign beacon_id = id_out;

endmodule
